// ----- rtl/zlxg_pkg.sv -----
// ----------------------------------------------------------------------------
// zlxg_pkg
// shared constants, field widths and codes for the zero-lag cross-correlation
// gradient accumulator
// ----------------------------------------------------------------------------
package zlxg_pkg;

  // parameter defaults
  localparam int GRID_POINTS_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 48;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int POINT_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_SIGMA   = 2'd0;
  localparam logic [OP_W-1:0] OP_EPSILON = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // kernel modes
  localparam logic [1:0] KERNEL_BORN = 2'd0;
  localparam logic [1:0] KERNEL_MIG  = 2'd1;
  localparam logic [1:0] KERNEL_TOMO = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_DECOMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EPSILON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_POROSITY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SATURATION = 3'd5;

endpackage

// ----- rtl/zlxg_ram.sv -----
// ----------------------------------------------------------------------------
// zlxg_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module zlxg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/zero_lag_xcorr_gradient_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// zero_lag_xcorr_gradient_accumulator_core
// sequence: from input beat to result beat an item passes ram read, two saturating
//   add steps, write-back with result load
// input: a new item is taken only after the last one is written back, set by the
//   read-modify-write sequence on the point rams
// reset: synchronous; control and config registers go to zero, then a clearing
//   pass zeroes both rams, one point a cycle, with no input accepted
// ----------------------------------------------------------------------------
module zero_lag_xcorr_gradient_accumulator_core #(
  parameter int GRID_POINTS = zlxg_pkg::GRID_POINTS_DEF,
  parameter int SAMPLE_BITS = zlxg_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = zlxg_pkg::ACC_BITS_DEF,
  parameter int IN_W  = ((zlxg_pkg::POINT_W + 8 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((zlxg_pkg::POINT_W + 3 * ACC_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_index, adj_x_up, adj_x_down, adj_y_up, adj_y_down,
  // oth_x_up, oth_x_down, oth_y_up, oth_y_down, zero pad
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // op
  input  logic [zlxg_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_point, total_value, part_a_value, part_b_value, zero pad
  output logic [OUT_W-1:0]                  m_axis_tdata,
  // updated
  output logic [0:0]                        m_axis_tuser,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [zlxg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zlxg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import zlxg_pkg::*;

  localparam int ADDR_W = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
  localparam int ENT_W  = 3 * ACC_BITS;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SUM_W-1:0]    SUM_MAX = SUM_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0]    SUM_MIN = SUM_W'(ACC_MIN);

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // what the item does to its point
  localparam logic [2:0] MODE_NONE  = 3'd0;  // op three or point out of range
  localparam logic [2:0] MODE_CLEAR = 3'd1;
  localparam logic [2:0] MODE_HOLD  = 3'd2;  // disabled target or kernel three with decomposition on
  localparam logic [2:0] MODE_BORN  = 3'd3;
  localparam logic [2:0] MODE_DEC   = 3'd4;  // migration or tomographic

  function automatic logic signed [ACC_BITS-1:0] sat_clip(input logic signed [SUM_W-1:0] s);
    logic signed [ACC_BITS-1:0] r;
    if (s > SUM_MAX) begin
      r = ACC_MAX;
    end else if (s < SUM_MIN) begin
      r = ACC_MIN;
    end else begin
      r = s[ACC_BITS-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [1:0] kernel_mode;
  logic       use_decomp;
  logic       inv_sigma;
  logic       inv_epsilon;
  logic       inv_porosity;
  logic       inv_saturation;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode    <= '0;
      use_decomp     <= 1'b0;
      inv_sigma      <= 1'b0;
      inv_epsilon    <= 1'b0;
      inv_porosity   <= 1'b0;
      inv_saturation <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_MODE:    kernel_mode    <= cfg_data[1:0];
        REG_USE_DECOMP:     use_decomp     <= cfg_data[0];
        REG_INV_SIGMA:      inv_sigma      <= cfg_data[0];
        REG_INV_EPSILON:    inv_epsilon    <= cfg_data[0];
        REG_INV_POROSITY:   inv_porosity   <= cfg_data[0];
        REG_INV_SATURATION: inv_saturation <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input unpack
  logic [POINT_W-1:0]            in_point;
  logic signed [SAMPLE_BITS-1:0] adj_x_up, adj_x_down, adj_y_up, adj_y_down;
  logic signed [SAMPLE_BITS-1:0] oth_x_up, oth_x_down, oth_y_up, oth_y_down;

  assign in_point   = s_axis_tdata[POINT_W-1:0];
  assign adj_x_up   = $signed(s_axis_tdata[POINT_W + 0*SAMPLE_BITS +: SAMPLE_BITS]);
  assign adj_x_down = $signed(s_axis_tdata[POINT_W + 1*SAMPLE_BITS +: SAMPLE_BITS]);
  assign adj_y_up   = $signed(s_axis_tdata[POINT_W + 2*SAMPLE_BITS +: SAMPLE_BITS]);
  assign adj_y_down = $signed(s_axis_tdata[POINT_W + 3*SAMPLE_BITS +: SAMPLE_BITS]);
  assign oth_x_up   = $signed(s_axis_tdata[POINT_W + 4*SAMPLE_BITS +: SAMPLE_BITS]);
  assign oth_x_down = $signed(s_axis_tdata[POINT_W + 5*SAMPLE_BITS +: SAMPLE_BITS]);
  assign oth_y_up   = $signed(s_axis_tdata[POINT_W + 6*SAMPLE_BITS +: SAMPLE_BITS]);
  assign oth_y_down = $signed(s_axis_tdata[POINT_W + 7*SAMPLE_BITS +: SAMPLE_BITS]);

  // ---------------------------------------------------------------- accept decode
  logic       in_beat;
  logic       in_range;
  logic       tomo;
  logic       born;
  logic       dec;
  logic       target_en;
  logic [2:0] in_mode;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign in_range = 32'(in_point) < 32'(GRID_POINTS);
  // cross terms only when the tomographic kernel really runs decomposed
  assign tomo     = use_decomp && (kernel_mode == KERNEL_TOMO);
  assign born     = (kernel_mode == KERNEL_BORN) || !use_decomp;
  assign dec      = use_decomp && (kernel_mode == KERNEL_MIG || kernel_mode == KERNEL_TOMO);

  // sigma follows sigma, porosity, saturation; epsilon follows any of the four
  assign target_en = (s_axis_tuser == OP_SIGMA)
                   ? (inv_sigma | inv_porosity | inv_saturation)
                   : (inv_sigma | inv_epsilon | inv_porosity | inv_saturation);

  always_comb begin
    in_mode = MODE_NONE;
    if (in_range) begin
      case (s_axis_tuser)
        OP_CLEAR: in_mode = MODE_CLEAR;
        OP_SIGMA, OP_EPSILON: begin
          if (!target_en)  in_mode = MODE_HOLD;
          else if (born)   in_mode = MODE_BORN;
          else if (dec)    in_mode = MODE_DEC;
          else             in_mode = MODE_HOLD;
        end
        default: in_mode = MODE_NONE;
      endcase
    end
  end

  // ---------------------------------------------------------------- item registers
  // products are taken at the input beat: partial a pairs adjoint-down with
  // other-down (migration) or other-up (tomographic), partial b the reverse;
  // born reuses the partial b products (up slots carry the full field)
  logic [2:0]               mode;
  logic                     is_eps;
  logic [POINT_W-1:0]       point;
  logic signed [PROD_W-1:0] pa1, pa2, pb1, pb2;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode   <= in_mode;
      is_eps <= s_axis_tuser == OP_EPSILON;
      point  <= in_point;
      pa1    <= adj_x_down * (tomo ? oth_x_up : oth_x_down);
      pa2    <= adj_y_down * (tomo ? oth_y_up : oth_y_down);
      pb1    <= adj_x_up * (tomo ? oth_x_down : oth_x_up);
      pb2    <= adj_y_up * (tomo ? oth_y_down : oth_y_up);
    end
  end

  // ---------------------------------------------------------------- point rams
  // one ram per target, each entry holds {part_b, part_a, total}
  logic              sig_we, eps_we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic [ENT_W-1:0]  sig_rdata, eps_rdata;
  logic [ADDR_W-1:0] clr_addr;

  zlxg_ram #(.WIDTH(ENT_W), .DEPTH(GRID_POINTS), .ADDR_W(ADDR_W)) u_sigma_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_beat),
    .raddr (ADDR_W'(in_point)),
    .rdata (sig_rdata)
  );

  zlxg_ram #(.WIDTH(ENT_W), .DEPTH(GRID_POINTS), .ADDR_W(ADDR_W)) u_epsilon_ram (
    .clk   (clk),
    .we    (eps_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_beat),
    .raddr (ADDR_W'(in_point)),
    .rdata (eps_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  logic [2:0] state;
  logic       out_free;
  logic       fin_go;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fin_go        = (state == ST_FIN) && out_free;
  assign s_axis_tready = state == ST_IDLE;

  // every item runs read, two add steps and write-back before the next one
  // is taken, so a read never overlaps a pending write to the same point
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          if (clr_addr == ADDR_W'(GRID_POINTS - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: if (in_beat) state <= ST_RD;
        ST_RD:   state <= ST_ACC;
        ST_ACC:  state <= ST_FIN;
        ST_FIN:  if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [ENT_W-1:0]           cur;
  logic signed [ACC_BITS-1:0] cur_t, cur_a, cur_b;
  logic signed [ACC_BITS-1:0] acc_t, acc_a, acc_b;
  logic signed [ACC_BITS-1:0] fin_t;

  assign cur   = is_eps ? eps_rdata : sig_rdata;
  assign cur_t = $signed(cur[0*ACC_BITS +: ACC_BITS]);
  assign cur_a = $signed(cur[1*ACC_BITS +: ACC_BITS]);
  assign cur_b = $signed(cur[2*ACC_BITS +: ACC_BITS]);

  // first product of each chain while the read data is fresh, second product
  // in the next cycle; stores that the mode leaves alone keep their value
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      acc_t <= (mode == MODE_BORN) ? sat_clip(SUM_W'(cur_t) + SUM_W'(pb1)) : cur_t;
      acc_a <= (mode == MODE_DEC)  ? sat_clip(SUM_W'(cur_a) + SUM_W'(pa1)) : cur_a;
      acc_b <= (mode == MODE_DEC)  ? sat_clip(SUM_W'(cur_b) + SUM_W'(pb1)) : cur_b;
    end else if (state == ST_ACC) begin
      if (mode == MODE_BORN) begin
        acc_t <= sat_clip(SUM_W'(acc_t) + SUM_W'(pb2));
      end
      if (mode == MODE_DEC) begin
        acc_a <= sat_clip(SUM_W'(acc_a) + SUM_W'(pa2));
        acc_b <= sat_clip(SUM_W'(acc_b) + SUM_W'(pb2));
      end
    end
  end

  // decomposed total is rebuilt from the two partials
  assign fin_t = (mode == MODE_DEC) ? sat_clip(SUM_W'(acc_a) + SUM_W'(acc_b)) : acc_t;

  // write-back: clearing pass and point clear hit both rams with zeros
  logic wb_item;

  assign wb_item = fin_go && (mode == MODE_BORN || mode == MODE_DEC);
  assign sig_we  = (state == ST_CLR) || (fin_go && mode == MODE_CLEAR) || (wb_item && !is_eps);
  assign eps_we  = (state == ST_CLR) || (fin_go && mode == MODE_CLEAR) || (wb_item && is_eps);
  assign waddr   = (state == ST_CLR) ? clr_addr : ADDR_W'(point);
  assign wdata   = (state == ST_CLR || mode == MODE_CLEAR) ? '0 : {acc_b, acc_a, fin_t};

  // ---------------------------------------------------------------- result register
  logic                       res_upd;
  logic signed [ACC_BITS-1:0] res_t, res_a, res_b;
  logic [POINT_W-1:0]         res_point;
  logic                       show_vals;

  assign show_vals = mode == MODE_HOLD || mode == MODE_BORN || mode == MODE_DEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_point <= point;
      res_upd   <= mode == MODE_CLEAR || mode == MODE_BORN || mode == MODE_DEC;
      res_t     <= show_vals ? fin_t : '0;
      res_a     <= show_vals ? acc_a : '0;
      res_b     <= show_vals ? acc_b : '0;
    end
  end

  assign m_axis_tdata = OUT_W'({res_b, res_a, res_t, res_point});
  assign m_axis_tuser = res_upd;

`ifndef SYNTHESIS
  // no ram write outside the clearing pass and the write-back cycle
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (sig_we || eps_we) |-> (state == ST_CLR || state == ST_FIN))
    else $error("ram written outside clearing pass or write-back");

  // nothing enters while the rams are being cleared
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  // a finished item always shows up as a result beat
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> m_axis_tvalid)
    else $error("write-back without result beat");

  // an item and a target write never go to both rams unless clearing
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    wb_item |-> (sig_we != eps_we))
    else $error("accumulate wrote both targets");
`endif

endmodule

// ----- tb/zero_lag_xcorr_gradient_accumulator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zero_lag_xcorr_gradient_accumulator_core_tb
// self-checking bench: drives field beats and register writes, predicts every
// result beat with an in-bench model of the per-point sigma and epsilon
// accumulators, and compares each result beat field by field in order
// ----------------------------------------------------------------------------
module zero_lag_xcorr_gradient_accumulator_core_tb;
  import zlxg_pkg::*;

  localparam int GRID         = GRID_POINTS_DEF;
  localparam int IN_BITS      = 144;
  localparam int OUT_BITS     = 160;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int MAX_PRINTS   = 40;

  // op three carries no meaning, the block must ignore it
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  // kernel mode three is unassigned, treated like a disabled target when decomposition is on
  localparam logic [1:0] KERNEL_RSVD = 2'd3;

  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 47);

  // one input beat: smp[0..7] = adj x up/down, adj y up/down, oth x up/down,
  // oth y up/down
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POINT_W-1:0] point;
    logic [7:0][15:0]   smp;
  } field_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               updated;
    logic [47:0]        total;
    logic [47:0]        part_a;
    logic [47:0]        part_b;
  } point_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_BITS-1:0]    s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  zero_lag_xcorr_gradient_accumulator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predicted stores, index 0 sigma, index 1 epsilon
  longint acc_total [2][GRID];
  longint acc_part_a[2][GRID];
  longint acc_part_b[2][GRID];

  // register copy
  logic [1:0] cur_kernel = KERNEL_BORN;
  bit cur_decomp, cur_inv_sigma, cur_inv_epsilon, cur_inv_porosity, cur_inv_saturation;

  point_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic point_result_t accumulate_point(input field_item_t it);
    point_result_t r;
    longint s[8];
    int t;
    bit enabled;
    r = '0;
    r.point = it.point;
    for (int i = 0; i < 8; i++) s[i] = longint'($signed(it.smp[i]));
    if (it.op == OP_CLEAR) begin
      for (int k = 0; k < 2; k++) begin
        acc_total[k][it.point]  = 0;
        acc_part_a[k][it.point] = 0;
        acc_part_b[k][it.point] = 0;
      end
      r.updated = 1'b1;
    end else if (it.op == OP_SIGMA || it.op == OP_EPSILON) begin
      t = (it.op == OP_EPSILON) ? 1 : 0;
      // epsilon is also enabled by its own bit, sigma is not
      enabled = cur_inv_sigma | cur_inv_porosity | cur_inv_saturation |
                (t == 1 && cur_inv_epsilon);
      if (enabled) begin
        if (cur_kernel == KERNEL_BORN || !cur_decomp) begin
          // up slots carry the full field
          acc_total[t][it.point] = clamp_acc(acc_total[t][it.point] + s[0] * s[4]);
          acc_total[t][it.point] = clamp_acc(acc_total[t][it.point] + s[2] * s[6]);
          r.updated = 1'b1;
        end else if (cur_kernel == KERNEL_MIG) begin
          acc_part_a[t][it.point] = clamp_acc(acc_part_a[t][it.point] + s[1] * s[5]);
          acc_part_a[t][it.point] = clamp_acc(acc_part_a[t][it.point] + s[3] * s[7]);
          acc_part_b[t][it.point] = clamp_acc(acc_part_b[t][it.point] + s[0] * s[4]);
          acc_part_b[t][it.point] = clamp_acc(acc_part_b[t][it.point] + s[2] * s[6]);
          acc_total[t][it.point] =
            clamp_acc(acc_part_a[t][it.point] + acc_part_b[t][it.point]);
          r.updated = 1'b1;
        end else if (cur_kernel == KERNEL_TOMO) begin
          // adjoint down with other up, adjoint up with other down
          acc_part_a[t][it.point] = clamp_acc(acc_part_a[t][it.point] + s[1] * s[4]);
          acc_part_a[t][it.point] = clamp_acc(acc_part_a[t][it.point] + s[3] * s[6]);
          acc_part_b[t][it.point] = clamp_acc(acc_part_b[t][it.point] + s[0] * s[5]);
          acc_part_b[t][it.point] = clamp_acc(acc_part_b[t][it.point] + s[2] * s[7]);
          acc_total[t][it.point] =
            clamp_acc(acc_part_a[t][it.point] + acc_part_b[t][it.point]);
          r.updated = 1'b1;
        end
      end
      // reserved kernel and disabled targets just report the stores
      r.total  = acc_total[t][it.point][47:0];
      r.part_a = acc_part_a[t][it.point][47:0];
      r.part_b = acc_part_b[t][it.point][47:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // result side: one beat per edge where tvalid and tready were both high
  always @(posedge clk) begin : result_check
    point_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat for point %0d with nothing pending",
                                  m_axis_tdata[11:0]));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[11:0] !== want.point)
          report_mismatch($sformatf("result_point %0d, want %0d",
                                    m_axis_tdata[11:0], want.point));
        if (m_axis_tuser[0] !== want.updated)
          report_mismatch($sformatf("point %0d updated %b, want %b",
                                    want.point, m_axis_tuser[0], want.updated));
        if (m_axis_tdata[59:12] !== want.total)
          report_mismatch($sformatf("point %0d total_value %h, want %h",
                                    want.point, m_axis_tdata[59:12], want.total));
        if (m_axis_tdata[107:60] !== want.part_a)
          report_mismatch($sformatf("point %0d part_a_value %h, want %h",
                                    want.point, m_axis_tdata[107:60], want.part_a));
        if (m_axis_tdata[155:108] !== want.part_b)
          report_mismatch($sformatf("point %0d part_b_value %h, want %h",
                                    want.point, m_axis_tdata[155:108], want.part_b));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // drive one beat and wait for it to be taken; tvalid is left high so the
  // next beat can follow back to back; idle cycles may come before each beat is offered
  task automatic send_item(input field_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, it.smp, it.point};
    s_axis_tuser  <= it.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(accumulate_point(it));
  endtask

  // stop offering beats and let every pending result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // idle on for a margin after the last result comes back
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] kernel, input bit decomp, input bit sig,
                            input bit eps, input bit por, input bit sat);
    logic [CFG_IDX_W-1:0]  idx[6];
    logic [CFG_DATA_W-1:0] val[6];
    idx = '{REG_KERNEL_MODE, REG_USE_DECOMP, REG_INV_SIGMA, REG_INV_EPSILON,
            REG_INV_POROSITY, REG_INV_SATURATION};
    val = '{kernel, {1'b0, decomp}, {1'b0, sig}, {1'b0, eps}, {1'b0, por}, {1'b0, sat}};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_kernel         = kernel;
    cur_decomp         = decomp;
    cur_inv_sigma      = sig;
    cur_inv_epsilon    = eps;
    cur_inv_porosity   = por;
    cur_inv_saturation = sat;
  endtask

  function automatic field_item_t uniform_item(input logic [OP_W-1:0] op,
                                               input logic [POINT_W-1:0] pt,
                                               input logic [15:0] adj,
                                               input logic [15:0] oth);
    field_item_t it;
    it.op    = op;
    it.point = pt;
    it.smp   = {oth, oth, oth, oth, adj, adj, adj, adj};
    return it;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic field_item_t rand_item();
    field_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 44)      it.op = OP_SIGMA;
    else if (pick < 88) it.op = OP_EPSILON;
    else if (pick < 96) it.op = OP_CLEAR;
    else                it.op = OP_IGNORED;
    // mostly a small set of points so the stores build up
    it.point = ($urandom_range(99) < 75) ? POINT_W'($urandom_range(15))
                                         : POINT_W'($urandom_range(GRID - 1));
    for (int i = 0; i < 8; i++) it.smp[i] = rand_sample();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // stores come out of the clearing pass at zero, both targets disabled
  task automatic test_power_on();
    send_item(uniform_item(OP_SIGMA, 12'd0, 16'h7fff, 16'h7fff));
    send_item(uniform_item(OP_EPSILON, 12'd4095, 16'h8000, 16'h8000));
  endtask

  // born kernel with full-scale samples, clear and the ignored op
  task automatic test_born_extremes();
    set_config(KERNEL_BORN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(uniform_item(OP_SIGMA, 12'd5, 16'h8000, 16'h8000));
    send_item(uniform_item(OP_SIGMA, 12'd5, 16'h8000, 16'h7fff));
    send_item(uniform_item(OP_SIGMA, 12'd4095, 16'h7fff, 16'h7fff));
    send_item(uniform_item(OP_EPSILON, 12'd5, 16'h7fff, 16'h8000));
    send_item(uniform_item(OP_IGNORED, 12'd5, 16'h7fff, 16'h7fff));
    send_item(uniform_item(OP_CLEAR, 12'd5, 16'h0000, 16'h0000));
    send_item(uniform_item(OP_SIGMA, 12'd5, 16'h0000, 16'h0000));
  endtask

  // each inversion bit alone against both targets
  task automatic test_target_enables();
    for (int b = 0; b < 4; b++) begin
      set_config(KERNEL_BORN, 1'b0, b == 0, b == 1, b == 2, b == 3);
      send_item(uniform_item(OP_SIGMA, 12'd7, 16'h1234, 16'hc001));
      send_item(uniform_item(OP_EPSILON, 12'd7, 16'h4000, 16'h0003));
    end
  endtask

  // decomposed kernels share the partial stores; reserved kernel and
  // decomposition off fall back as described
  task automatic test_decomposed();
    field_item_t it;
    it.op    = OP_SIGMA;
    it.point = 12'd9;
    it.smp   = {16'h0700, 16'hf800, 16'h0500, 16'h0400, 16'hfd00, 16'h0200, 16'hff00, 16'h0100};
    set_config(KERNEL_MIG, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(it);
    set_config(KERNEL_TOMO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(it);
    set_config(KERNEL_RSVD, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(it);
    set_config(KERNEL_MIG, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    it.op = OP_EPSILON;
    send_item(it);
  endtask

  // full-scale products piled onto one point, positive through the
  // migration partials and negative through the tomographic cross terms
  task automatic test_full_scale();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(KERNEL_MIG, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(uniform_item(OP_CLEAR, 12'd100, 16'h0000, 16'h0000));
    // each beat adds 2^31 to both partials
    repeat (100) send_item(uniform_item(OP_SIGMA, 12'd100, 16'h8000, 16'h8000));
    set_config(KERNEL_BORN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_item(uniform_item(OP_SIGMA, 12'd100, 16'h8000, 16'h8000));
    send_item(uniform_item(OP_CLEAR, 12'd100, 16'h0000, 16'h0000));
    set_config(KERNEL_TOMO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    // negative products on both partials
    repeat (100) send_item(uniform_item(OP_EPSILON, 12'd100, 16'h8000, 16'h7fff));
    set_config(KERNEL_BORN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_item(uniform_item(OP_EPSILON, 12'd100, 16'h8000, 16'h7fff));
  endtask

  // receiver holds off long enough for the block to fill and stall its
  // input, then the sender waits for every result
  task automatic test_backpressure();
    set_config(KERNEL_MIG, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    repeat (40) send_item(rand_item());
    wait_drained();
  endtask

  // random beats under four idling patterns and many register settings
  task automatic test_random();
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 67, 0, 34};
    recv_pct = '{0, 0, 67, 34};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 5; k++) begin
        if (p == 0 && k == 0)
          set_config(KERNEL_BORN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        else if (p == 0 && k == 1)
          set_config(KERNEL_RSVD, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        else if (p == 1 && k == 0)
          set_config(KERNEL_TOMO, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        else
          set_config(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_idle_pct  = send_pct[p];
        recv_stall_pct = recv_pct[p];
        repeat (90) send_item(rand_item());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // the first beat waits out the clearing pass through tready
    test_power_on();
    test_born_extremes();
    test_target_enables();
    test_decomposed();
    test_full_scale();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
